>>> hw/rtl/assert_macros.svh
// Assertion helpers; empty under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define SCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SCC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/scc_pkg.sv
package scc_pkg;

   localparam int NUM_LINES = 4;
   localparam int LINE_W    = 2;
   localparam int SPL_W     = 7;
   localparam logic [SPL_W-1:0] SPL_RESET = 7'd4;
   localparam logic [SPL_W-1:0] SPL_MAX   = 7'd64;

   localparam logic [2:0] OP_READ      = 3'd0;
   localparam logic [2:0] OP_WRITE     = 3'd1;
   localparam logic [2:0] OP_FLUSH     = 3'd2;
   localparam logic [2:0] OP_INVAL     = 3'd3;
   localparam logic [2:0] OP_FILL_STAT = 3'd4;

   localparam logic [2:0] KIND_HIT    = 3'd0;
   localparam logic [2:0] KIND_IOERR  = 3'd1;
   localparam logic [2:0] KIND_FILL   = 3'd2;
   localparam logic [2:0] KIND_WB     = 3'd3;
   localparam logic [2:0] KIND_BYPASS = 3'd4;
   localparam logic [2:0] KIND_DONE   = 3'd5;
   localparam logic [2:0] KIND_RETRY  = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_LONG, ST_FLUSH, ST_LOOKUP,
      ST_FILL, ST_RETRY, ST_BYPASS, ST_FINAL
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_LOAD, ACT_FINAL, ACT_SCAN_LONG, ACT_SCAN_FLUSH,
      ACT_BYPASS, ACT_LOOKUP, ACT_FILL, ACT_RETRY
   } act_type;

   typedef struct packed {
      act_type act;
   } cmd_type;

   typedef struct packed {
      logic rw;
      logic zero_count;
      logic long_req;
      logic flush;
      logic hit_found;
      logic idx_last;
   } status_type;

endpackage

>>> hw/rtl/sector_cache_controller.sv
// Write-back sector cache tag controller with four lines and round-robin
// replacement. Issue a transaction by raising start while busy is low; busy
// stays high until the controller has issued every command of it. Results
// come out one per strobe on rsp_valid, each for exactly one cycle, and the
// receiver cannot stall them: it must take every strobed transaction as it
// appears. The last result of a request carries rsp_last. Steps: zero-count,
// invalidate, fill status and unknown ops go from dispatch to the final
// result; a lookup gives its result on a hit, and on a miss a write-back of a
// dirty victim, a fill and a retry result; a long request or a flush scans
// the lines one per cycle, then gives the bypass or the final result.
// sectors_per_line sits at byte address 0 of the APB port; write it only
// while busy is low.
module sector_cache_controller import scc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_drive,
   input  logic [31:0] req_lba,
   input  logic [15:0] req_count,
   input  logic [1:0]  req_line,
   input  logic        req_failed,
   // result channel
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_line_index,
   output logic [31:0] rsp_disk_sector,
   output logic [5:0]  rsp_line_offset,
   output logic [15:0] rsp_sector_count,
   output logic        rsp_is_write,
   output logic        rsp_last,
   // APB register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cmd_type          cmd;
   status_type       status;
   logic             cfg_we;
   logic [SPL_W-1:0] cfg_spl;
   logic             reg_hit;

   // Only one register: decode the word address bit.
   assign reg_hit = (paddr[2] == 1'b0);
   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite && reg_hit;
   assign prdata  = reg_hit ? {25'b0, cfg_spl} : 32'b0;

   // Sequence the request one step per cycle.
   scc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Hold line state, compare tags and drive the result register.
   scc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_drive        (req_drive),
      .req_lba          (req_lba),
      .req_count        (req_count),
      .req_line         (req_line),
      .req_failed       (req_failed),
      .cfg_we           (cfg_we),
      .cfg_wdata        (pwdata[SPL_W-1:0]),
      .cfg_spl          (cfg_spl),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_line_index   (rsp_line_index),
      .rsp_disk_sector  (rsp_disk_sector),
      .rsp_line_offset  (rsp_line_offset),
      .rsp_sector_count (rsp_sector_count),
      .rsp_is_write     (rsp_is_write),
      .rsp_last         (rsp_last)
   );

endmodule

>>> hw/rtl/scc_ctrl.sv
`include "assert_macros.svh"

module scc_ctrl import scc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.act  = ACT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.act  = ACT_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (status.rw && status.zero_count) begin
               cmd.act  = ACT_FINAL;
               state_in = ST_IDLE;
            end else if (status.rw && status.long_req) begin
               state_in = ST_LONG;
            end else if (status.rw) begin
               state_in = ST_LOOKUP;
            end else if (status.flush) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.act  = ACT_FINAL;
               state_in = ST_IDLE;
            end
         end
         ST_LONG: begin
            cmd.act = ACT_SCAN_LONG;
            if (status.idx_last) state_in = ST_BYPASS;
         end
         ST_FLUSH: begin
            cmd.act = ACT_SCAN_FLUSH;
            if (status.idx_last) state_in = ST_FINAL;
         end
         ST_LOOKUP: begin
            cmd.act  = ACT_LOOKUP;
            state_in = status.hit_found ? ST_IDLE : ST_FILL;
         end
         ST_FILL: begin
            cmd.act  = ACT_FILL;
            state_in = ST_RETRY;
         end
         ST_RETRY: begin
            cmd.act  = ACT_RETRY;
            state_in = ST_IDLE;
         end
         ST_BYPASS: begin
            cmd.act  = ACT_BYPASS;
            state_in = ST_IDLE;
         end
         ST_FINAL: begin
            cmd.act  = ACT_FINAL;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `SCC_ASSERT_NEXT(a_fill_then_retry, clock, reset, state_ff == ST_FILL, state_ff == ST_RETRY)
   `SCC_ASSERT_NEXT(a_long_ends_bypass, clock, reset, state_ff == ST_LONG && status.idx_last, state_ff == ST_BYPASS)
   `SCC_ASSERT_NEXT(a_accept_dispatch, clock, reset, state_ff == ST_IDLE && start, state_ff == ST_DISPATCH)

endmodule

>>> hw/rtl/scc_dpath.sv
`include "assert_macros.svh"

module scc_dpath import scc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_drive,
   input  logic [31:0] req_lba,
   input  logic [15:0] req_count,
   input  logic [1:0]  req_line,
   input  logic        req_failed,
   input  logic        cfg_we,
   input  logic [SPL_W-1:0] cfg_wdata,
   output logic [SPL_W-1:0] cfg_spl,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_line_index,
   output logic [31:0] rsp_disk_sector,
   output logic [5:0]  rsp_line_offset,
   output logic [15:0] rsp_sector_count,
   output logic        rsp_is_write,
   output logic        rsp_last
);

   logic [SPL_W-1:0] spl_ff;
   logic [2:0]  op_ff, op_in;
   logic [3:0]  disk_ff, disk_in;
   logic [31:0] sector_ff, sector_in;
   logic [15:0] count_ff, count_in;
   logic [1:0]  line_ff, line_in;
   logic        failed_ff, failed_in;

   logic [NUM_LINES-1:0] valid_ff, valid_in, dirty_ff, dirty_in, error_ff, error_in;
   logic [3:0]  ldisk_ff [NUM_LINES];
   logic [3:0]  ldisk_in [NUM_LINES];
   logic [31:0] tag_ff [NUM_LINES];
   logic [31:0] tag_in [NUM_LINES];
   logic [LINE_W-1:0] vptr_ff, vptr_in, idx_ff, idx_in;

   logic        o_valid_ff, o_valid_in, o_wr_ff, o_wr_in, o_last_ff, o_last_in;
   logic [2:0]  o_kind_ff, o_kind_in;
   logic [1:0]  o_line_ff, o_line_in;
   logic [31:0] o_ds_ff, o_ds_in;
   logic [5:0]  o_off_ff, o_off_in;
   logic [15:0] o_cnt_ff, o_cnt_in;

   logic [SPL_W-1:0] spl_eff;
   logic [32:0] req_end;
   logic [32:0] tag_end [NUM_LINES];
   logic [NUM_LINES-1:0] owned, ovl, fit;
   logic              hit_found;
   logic [LINE_W-1:0] hit_idx;

   always_comb begin
      priority if (spl_ff == '0) spl_eff = SPL_W'(1);
      else if (spl_ff > SPL_MAX) spl_eff = SPL_MAX;
      else spl_eff = spl_ff;
   end

   assign req_end = {1'b0, sector_ff} + {17'b0, count_ff};

   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         tag_end[i] = {1'b0, tag_ff[i]} + {26'b0, spl_eff};
         owned[i]   = valid_ff[i] && (ldisk_ff[i] == disk_ff);
         ovl[i]     = owned[i] && ({1'b0, tag_ff[i]} < req_end)
                      && (tag_end[i] > {1'b0, sector_ff});
         fit[i]     = owned[i] && (tag_ff[i] <= sector_ff) && (tag_end[i] >= req_end);
         if (fit[i]) begin
            hit_found = 1'b1;
            hit_idx   = LINE_W'(i);
         end
      end
   end

   assign status.rw         = (op_ff == OP_READ) || (op_ff == OP_WRITE);
   assign status.zero_count = (count_ff == '0);
   assign status.long_req   = ({9'b0, count_ff} > {18'b0, spl_eff} );
   assign status.flush      = (op_ff == OP_FLUSH);
   assign status.hit_found  = hit_found;
   assign status.idx_last   = (idx_ff == LINE_W'(NUM_LINES - 1));

   always_comb begin
      op_in = op_ff; disk_in = disk_ff; sector_in = sector_ff; count_in = count_ff;
      line_in = line_ff; failed_in = failed_ff;
      valid_in = valid_ff; dirty_in = dirty_ff; error_in = error_ff;
      ldisk_in = ldisk_ff; tag_in = tag_ff;
      vptr_in = vptr_ff; idx_in = idx_ff;
      o_valid_in = 1'b0; o_kind_in = KIND_DONE; o_line_in = '0; o_ds_in = '0;
      o_off_in = '0; o_cnt_in = '0; o_wr_in = 1'b0; o_last_in = 1'b0;
      unique case (cmd.act)
         ACT_NONE: begin
         end
         ACT_LOAD: begin
            op_in = req_op; disk_in = req_drive; sector_in = req_lba;
            count_in = req_count; line_in = req_line; failed_in = req_failed;
            idx_in = '0;
         end
         ACT_FINAL: begin
            o_valid_in = 1'b1;
            o_kind_in  = KIND_DONE;
            o_last_in  = 1'b1;
            if (op_ff == OP_INVAL) begin
               valid_in = valid_ff & ~owned;
               dirty_in = dirty_ff & ~owned;
            end
            if (op_ff == OP_FILL_STAT) begin
               o_line_in = line_ff;
               if (failed_ff) error_in[line_ff] = 1'b1;
            end
         end
         ACT_SCAN_LONG: begin
            if (ovl[idx_ff]) begin
               if (dirty_ff[idx_ff]) begin
                  o_valid_in = 1'b1; o_kind_in = KIND_WB; o_line_in = idx_ff;
                  o_ds_in = tag_ff[idx_ff]; o_cnt_in = 16'(spl_eff); o_wr_in = 1'b1;
               end
               valid_in[idx_ff] = 1'b0;
               dirty_in[idx_ff] = 1'b0;
            end
            idx_in = idx_ff + 1'b1;
         end
         ACT_SCAN_FLUSH: begin
            if (owned[idx_ff] && dirty_ff[idx_ff]) begin
               o_valid_in = 1'b1; o_kind_in = KIND_WB; o_line_in = idx_ff;
               o_ds_in = tag_ff[idx_ff]; o_cnt_in = 16'(spl_eff); o_wr_in = 1'b1;
               dirty_in[idx_ff] = 1'b0;
            end
            idx_in = idx_ff + 1'b1;
         end
         ACT_BYPASS: begin
            o_valid_in = 1'b1; o_kind_in = KIND_BYPASS; o_ds_in = sector_ff;
            o_cnt_in = count_ff; o_wr_in = op_ff[0]; o_last_in = 1'b1;
         end
         ACT_LOOKUP: begin
            if (hit_found) begin
               o_valid_in = 1'b1; o_line_in = hit_idx; o_last_in = 1'b1;
               if (error_ff[hit_idx]) begin
                  o_kind_in = KIND_IOERR;
                  valid_in[hit_idx] = 1'b0;
                  dirty_in[hit_idx] = 1'b0;
               end else begin
                  o_kind_in = KIND_HIT;
                  o_off_in  = 6'(sector_ff - tag_ff[hit_idx]);
                  o_cnt_in  = count_ff;
                  o_wr_in   = op_ff[0];
                  if (op_ff[0]) dirty_in[hit_idx] = 1'b1;
               end
            end else if (valid_ff[vptr_ff] && dirty_ff[vptr_ff]) begin
               o_valid_in = 1'b1; o_kind_in = KIND_WB; o_line_in = vptr_ff;
               o_ds_in = tag_ff[vptr_ff]; o_cnt_in = 16'(spl_eff); o_wr_in = 1'b1;
            end
         end
         ACT_FILL: begin
            valid_in[vptr_ff] = 1'b1;
            dirty_in[vptr_ff] = 1'b0;
            error_in[vptr_ff] = 1'b0;
            ldisk_in[vptr_ff] = disk_ff;
            tag_in[vptr_ff]   = sector_ff;
            vptr_in = vptr_ff + 1'b1;
            o_valid_in = 1'b1; o_kind_in = KIND_FILL; o_line_in = vptr_ff;
            o_ds_in = sector_ff; o_cnt_in = 16'(spl_eff);
         end
         ACT_RETRY: begin
            o_valid_in = 1'b1; o_kind_in = KIND_RETRY; o_last_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spl_ff     <= SPL_RESET;
         valid_ff   <= '0;
         dirty_ff   <= '0;
         error_ff   <= '0;
         vptr_ff    <= '0;
         idx_ff     <= '0;
         o_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LINES; i++) begin
            ldisk_ff[i] <= '0;
            tag_ff[i]   <= '0;
         end
      end else begin
         if (cfg_we) spl_ff <= cfg_wdata;
         valid_ff   <= valid_in;
         dirty_ff   <= dirty_in;
         error_ff   <= error_in;
         vptr_ff    <= vptr_in;
         idx_ff     <= idx_in;
         o_valid_ff <= o_valid_in;
         ldisk_ff   <= ldisk_in;
         tag_ff     <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; disk_ff <= disk_in; sector_ff <= sector_in;
      count_ff <= count_in; line_ff <= line_in; failed_ff <= failed_in;
      o_kind_ff <= o_kind_in; o_line_ff <= o_line_in; o_ds_ff <= o_ds_in;
      o_off_ff <= o_off_in; o_cnt_ff <= o_cnt_in; o_wr_ff <= o_wr_in;
      o_last_ff <= o_last_in;
   end

   assign cfg_spl          = spl_ff;
   assign rsp_valid        = o_valid_ff;
   assign rsp_kind         = o_kind_ff;
   assign rsp_line_index   = o_line_ff;
   assign rsp_disk_sector  = o_ds_ff;
   assign rsp_line_offset  = o_off_ff;
   assign rsp_sector_count = o_cnt_ff;
   assign rsp_is_write     = o_wr_ff;
   assign rsp_last         = o_last_ff;

   `SCC_ASSERT_NEXT(a_fill_retry_out, clock, reset, o_valid_ff && o_kind_ff == KIND_FILL, o_valid_ff && o_kind_ff == KIND_RETRY)
   `SCC_ASSERT_NOW(a_dirty_valid, clock, reset, 1'b1, (dirty_ff & ~valid_ff) == '0)

endmodule

>>> test/sector_cache_controller_tb.sv
`timescale 1ns / 1ps

module sector_cache_controller_tb import scc_pkg::*; ();

   localparam int IDLE_PCT   = 29;
   localparam int RAND_ITEMS = 80;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;

   // one result of the controller, one field per port
   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  line_index;
      logic [31:0] disk_sector;
      logic [5:0]  line_offset;
      logic [15:0] sector_count;
      logic        is_write;
      logic        last;
   } cache_cmd_type;

   // one request, with an optional typed-in expectation for the directed table
   typedef struct {
      logic [2:0]  op;
      logic [3:0]  disk;
      logic [31:0] sector;
      logic [15:0] count;
      logic [1:0]  line;
      logic        failed;
      bit          has_fixed;
      cache_cmd_type fixed;
   } cache_req_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [3:0]  req_drive;
   logic [31:0] req_lba;
   logic [15:0] req_count;
   logic [1:0]  req_line;
   logic        req_failed;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [1:0]  rsp_line_index;
   logic [31:0] rsp_disk_sector;
   logic [5:0]  rsp_line_offset;
   logic [15:0] rsp_sector_count;
   logic        rsp_is_write;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   sector_cache_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_drive        (req_drive),
      .req_lba          (req_lba),
      .req_count        (req_count),
      .req_line         (req_line),
      .req_failed       (req_failed),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_line_index   (rsp_line_index),
      .rsp_disk_sector  (rsp_disk_sector),
      .rsp_line_offset  (rsp_line_offset),
      .rsp_sector_count (rsp_sector_count),
      .rsp_is_write     (rsp_is_write),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // shadow copy of the tag store, used to predict every command
   logic        shadow_valid [NUM_LINES];
   logic        shadow_dirty [NUM_LINES];
   logic        shadow_error [NUM_LINES];
   logic [3:0]  shadow_disk  [NUM_LINES];
   logic [31:0] shadow_tag   [NUM_LINES];
   logic [1:0]  shadow_victim;
   logic [6:0]  shadow_spl;

   cache_cmd_type pending_cmds[$];
   int          error_count;
   int          stall_cycles;
   bit          timed_out;
   bit          no_idle;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic cache_cmd_type make_cmd(logic [2:0] kind, logic [1:0] li,
                                              logic [31:0] ds, logic [5:0] off,
                                              logic [15:0] cnt, logic wr, logic lst);
      cache_cmd_type c;
      c.kind = kind; c.line_index = li; c.disk_sector = ds; c.line_offset = off;
      c.sector_count = cnt; c.is_write = wr; c.last = lst;
      return c;
   endfunction

   // walk one request through the shadow tag store and queue its commands
   task automatic predict_commands(input cache_req_type r, output cache_cmd_type cmds[$]);
      logic [32:0] spl;
      logic [32:0] req_end;
      logic [32:0] tag_end;
      int          hit;
      int          v;
      cmds = {};
      spl = (shadow_spl == 0) ? 33'd1 : (shadow_spl > SPL_MAX) ? 33'd64 : 33'(shadow_spl);
      req_end = 33'(r.sector) + 33'(r.count);
      if (r.op == OP_READ || r.op == OP_WRITE) begin
         if (r.count == 0) begin
            cmds.push_back(make_cmd(KIND_DONE, 0, 0, 0, 0, 0, 1));
         end else if (33'(r.count) > spl) begin
            for (int i = 0; i < NUM_LINES; i++) begin
               tag_end = 33'(shadow_tag[i]) + spl;
               if (shadow_valid[i] && shadow_disk[i] == r.disk &&
                   33'(shadow_tag[i]) < req_end && tag_end > 33'(r.sector)) begin
                  if (shadow_dirty[i])
                     cmds.push_back(make_cmd(KIND_WB, 2'(i), shadow_tag[i], 0,
                                             spl[15:0], 1, 0));
                  shadow_valid[i] = 0;
                  shadow_dirty[i] = 0;
               end
            end
            cmds.push_back(make_cmd(KIND_BYPASS, 0, r.sector, 0, r.count, r.op[0], 1));
         end else begin
            hit = -1;
            for (int i = 0; i < NUM_LINES; i++) begin
               tag_end = 33'(shadow_tag[i]) + spl;
               if (shadow_valid[i] && shadow_disk[i] == r.disk &&
                   shadow_tag[i] <= r.sector && tag_end >= req_end)
                  hit = i;
            end
            if (hit >= 0) begin
               if (shadow_error[hit]) begin
                  shadow_valid[hit] = 0;
                  shadow_dirty[hit] = 0;
                  cmds.push_back(make_cmd(KIND_IOERR, 2'(hit), 0, 0, 0, 0, 1));
               end else begin
                  if (r.op[0]) shadow_dirty[hit] = 1;
                  cmds.push_back(make_cmd(KIND_HIT, 2'(hit), 0,
                                          6'(r.sector - shadow_tag[hit]),
                                          r.count, r.op[0], 1));
               end
            end else begin
               v = int'(shadow_victim);
               if (shadow_valid[v] && shadow_dirty[v])
                  cmds.push_back(make_cmd(KIND_WB, 2'(v), shadow_tag[v], 0, spl[15:0], 1, 0));
               shadow_valid[v] = 1;
               shadow_dirty[v] = 0;
               shadow_error[v] = 0;
               shadow_disk[v]  = r.disk;
               shadow_tag[v]   = r.sector;
               shadow_victim   = shadow_victim + 2'd1;
               cmds.push_back(make_cmd(KIND_FILL, 2'(v), r.sector, 0, spl[15:0], 0, 0));
               cmds.push_back(make_cmd(KIND_RETRY, 0, 0, 0, 0, 0, 1));
            end
         end
      end else if (r.op == OP_FLUSH) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            if (shadow_valid[i] && shadow_dirty[i] && shadow_disk[i] == r.disk) begin
               cmds.push_back(make_cmd(KIND_WB, 2'(i), shadow_tag[i], 0, spl[15:0], 1, 0));
               shadow_dirty[i] = 0;
            end
         end
         cmds.push_back(make_cmd(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end else if (r.op == OP_INVAL) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            if (shadow_valid[i] && shadow_disk[i] == r.disk) begin
               shadow_valid[i] = 0;
               shadow_dirty[i] = 0;
            end
         end
         cmds.push_back(make_cmd(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end else if (r.op == OP_FILL_STAT) begin
         if (r.failed) shadow_error[r.line] = 1;
         cmds.push_back(make_cmd(KIND_DONE, r.line, 0, 0, 0, 0, 1));
      end else begin
         cmds.push_back(make_cmd(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end
   endtask

   // compare every strobed command with the oldest prediction
   always @(posedge clock) begin
      cache_cmd_type want;
      if (!reset && rsp_valid) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected command kind", 32'(rsp_kind), 32'd0);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_line_index !== want.line_index)
               report_mismatch("line_index", rsp_line_index, want.line_index);
            if (rsp_disk_sector !== want.disk_sector)
               report_mismatch("disk_sector", rsp_disk_sector, want.disk_sector);
            if (rsp_line_offset !== want.line_offset)
               report_mismatch("line_offset", rsp_line_offset, want.line_offset);
            if (rsp_sector_count !== want.sector_count)
               report_mismatch("sector_count", rsp_sector_count, want.sector_count);
            if (rsp_is_write !== want.is_write)
               report_mismatch("is_write", rsp_is_write, want.is_write);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // watchdog: count cycles in which no transaction moves on either side
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // APB write (setup, then access phase), then read back
   task automatic write_spl(input logic [6:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // prdata as seen in the read access cycle
      if (prdata[6:0] !== value)
         report_mismatch("sectors_per_line readback", prdata, 32'(value));
      psel <= 1'b0; penable <= 1'b0;
      shadow_spl = value;
   endtask

   // present one request and hold it until the controller takes it; start
   // stays high into the next request unless the sender idles
   task automatic issue_request(input cache_req_type r);
      cache_cmd_type cmds[$];
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
         while (!no_idle && $urandom_range(99) < IDLE_PCT) @(posedge clock);
      end
      start <= 1'b1; req_op <= r.op; req_drive <= r.disk; req_lba <= r.sector;
      req_count <= r.count; req_line <= r.line; req_failed <= r.failed;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_commands(r, cmds);
      if (r.has_fixed && (cmds.size() != 1 || cmds[0] != r.fixed))
         report_mismatch("table row kind", 32'(r.fixed.kind), 32'(cmds[0].kind));
      foreach (cmds[k]) pending_cmds.push_back(cmds[k]);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic cache_req_type mk(logic [2:0] op, logic [3:0] d, logic [31:0] s,
                                        logic [15:0] c, logic [1:0] l, logic f);
      cache_req_type r;
      r.op = op; r.disk = d; r.sector = s; r.count = c; r.line = l; r.failed = f;
      r.has_fixed = 0; r.fixed = '0;
      return r;
   endfunction

   function automatic cache_req_type mk_fixed(cache_req_type r, cache_cmd_type c);
      r.has_fixed = 1; r.fixed = c;
      return r;
   endfunction

   // random request biased toward a small working set so lookups hit
   function automatic cache_req_type rand_request;
      cache_req_type r;
      int pick;
      pick = $urandom_range(99);
      r = mk(3'($urandom_range(7)), 4'($urandom_range(2)), 32'($urandom_range(40)),
             16'($urandom_range(8)), 2'($urandom), 1'($urandom));
      if (pick < 60) r.op = 3'($urandom_range(1));
      if (pick < 8) begin
         r.sector = $urandom;
         r.disk = 4'($urandom);
         r.count = 16'($urandom);
      end else if (pick < 12) begin
         r.sector = 32'hFFFF_FFF0 + $urandom_range(15);
      end
      return r;
   endfunction

   cache_req_type directed[$];

   initial begin
      error_count = 0; stall_cycles = 0; timed_out = 0; no_idle = 0;
      reset = 1'b1; start = 1'b0; req_op = OP_READ; req_drive = '0; req_lba = '0;
      req_count = '0; req_line = '0; req_failed = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         shadow_valid[i] = 0; shadow_dirty[i] = 0; shadow_error[i] = 0;
         shadow_disk[i] = 0; shadow_tag[i] = 0;
      end
      shadow_victim = 0;
      shadow_spl = SPL_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: zero count, unknown ops, fill status, miss/hit, flush, invalidate, long request, edges
      directed.push_back(mk_fixed(mk(OP_READ, 0, 0, 0, 0, 0),
                                  make_cmd(KIND_DONE, 0, 0, 0, 0, 0, 1)));
      directed.push_back(mk_fixed(mk(3'd7, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 3, 1),
                                  make_cmd(KIND_DONE, 0, 0, 0, 0, 0, 1)));
      directed.push_back(mk_fixed(mk(3'd5, 0, 0, 0, 0, 0),
                                  make_cmd(KIND_DONE, 0, 0, 0, 0, 0, 1)));
      directed.push_back(mk(OP_WRITE, 4'hF, 32'hFFFF_FFFF, 1, 0, 0));
      directed.push_back(mk(OP_WRITE, 4'hF, 32'hFFFF_FFFF, 1, 0, 0));
      directed.push_back(mk(OP_READ, 1, 100, 4, 0, 0));
      directed.push_back(mk(OP_WRITE, 1, 102, 2, 0, 0));
      directed.push_back(mk(OP_READ, 1, 103, 1, 0, 0));
      directed.push_back(mk_fixed(mk(OP_FILL_STAT, 0, 0, 0, 2, 1),
                                  make_cmd(KIND_DONE, 2, 0, 0, 0, 0, 1)));
      directed.push_back(mk(OP_READ, 2, 200, 3, 0, 0));
      directed.push_back(mk(OP_READ, 2, 200, 3, 0, 0));
      directed.push_back(mk(OP_WRITE, 3, 300, 4, 0, 0));
      directed.push_back(mk(OP_WRITE, 3, 301, 1, 0, 0));
      directed.push_back(mk(OP_FLUSH, 3, 0, 0, 0, 0));
      directed.push_back(mk(OP_FLUSH, 1, 0, 0, 0, 0));
      directed.push_back(mk(OP_WRITE, 1, 102, 2, 0, 0));
      directed.push_back(mk(OP_READ, 1, 98, 5, 0, 0));
      directed.push_back(mk(OP_WRITE, 0, 0, 16'hFFFF, 0, 0));
      directed.push_back(mk(OP_INVAL, 3, 0, 0, 0, 0));
      directed.push_back(mk(OP_FILL_STAT, 0, 0, 0, 1, 0));
      directed.push_back(mk(OP_READ, 4'hF, 32'hFFFF_FFFC, 4, 0, 0));
      foreach (directed[k]) issue_request(directed[k]);

      // hold off until the controller has drained, then sweep the register
      drain();
      write_spl(7'd1);
      for (int k = 0; k < 8; k++) issue_request(rand_request());
      drain();
      write_spl(7'd64);
      directed = {};
      directed.push_back(mk(OP_WRITE, 5, 1000, 64, 0, 0));
      directed.push_back(mk(OP_READ, 5, 1063, 1, 0, 0));
      directed.push_back(mk(OP_READ, 5, 1000, 65, 0, 0));
      foreach (directed[k]) issue_request(directed[k]);
      drain();
      write_spl(7'd0);
      for (int k = 0; k < 8; k++) issue_request(rand_request());
      drain();
      write_spl(7'd127);
      for (int k = 0; k < 8; k++) issue_request(rand_request());
      drain();
      write_spl(7'd4);

      // main random run, with one stretch where the sender never idles
      for (int k = 0; k < RAND_ITEMS; k++) begin
         no_idle = (k >= 30 && k < 60);
         if ((k % 30) == 29) write_spl(7'($urandom_range(1, 16)));
         issue_request(rand_request());
         if ((k % 30) == 28) drain();
      end
      no_idle = 0;
      drain();

      if (error_count == 0 && pending_cmds.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/scc_pkg.sv
hw/rtl/scc_ctrl.sv
hw/rtl/scc_dpath.sv
hw/rtl/sector_cache_controller.sv
test/sector_cache_controller_tb.sv
